/* hdl/pidm_pkg.sv */
// Shared widths, reset values and register indexes for the PID position motor drive.
// Used by pidm_gain_mul and pid_position_motor_drive_unit; depends on nothing else.
`default_nettype none

package pidm_pkg;

  localparam int POS_W   = 32;  // position and error width
  localparam int DIFF_W  = POS_W + 1;
  localparam int SUM_W   = 48;  // integral accumulator width
  localparam int GAIN_W  = 40;  // gain register width
  localparam int FRAC_W  = 24;  // gain fraction bits
  localparam int LIMIT_W = 16;  // drive limit and duty width

  // Gain x value product, both split in halves for the partial products.
  localparam int GAIN_LO_W = GAIN_W / 2;
  localparam int GAIN_HI_W = GAIN_W - GAIN_LO_W;
  localparam int VAL_LO_W  = SUM_W / 2;
  localparam int VAL_HI_W  = SUM_W - VAL_LO_W;
  localparam int LO_W      = GAIN_HI_W + VAL_LO_W + GAIN_LO_W + 1;
  localparam int HI_W      = GAIN_HI_W + VAL_HI_W + GAIN_LO_W + 2;
  localparam int PROD_W    = HI_W + VAL_LO_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = GAIN_W;

  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = GAIN_W'(33554432);
  localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST  = GAIN_W'(168);
  localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST  = GAIN_W'(1677721600);
  localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST = LIMIT_W'(999);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN   = 2'd0,
    CFG_INTEG_GAIN  = 2'd1,
    CFG_DERIV_GAIN  = 2'd2,
    CFG_DRIVE_LIMIT = 2'd3
  } cfg_idx_t;

endpackage

`default_nettype wire

/* hdl/pid_position_motor_drive_unit.sv */
// Top level of the saturated PID position controller with clamped drive output.
// Depends on pidm_pkg and on pidm_gain_mul for the three gain products.
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  s_       | s_tvalid / s_tready | s_tdata: target_pos, measured_pos
//  m_       | m_tvalid / m_tready | m_tdata: duty; m_tuser: forward, clamped
//  cfg_     | cfg_valid/cfg_ready | cfg_index, cfg_data (gains, drive limit)
//
// One request is accepted per cycle while the output is not stalled. The error
// register loads at the edge that accepts a request; the integrator stage, the
// three-stage gain multipliers, two adder stages and the clamp and output
// register follow it in that order.
// Reset clears all pipeline valids, the integral and the previous error, and
// loads the default gains and limit. The config port is always ready.
// While m_tready is low with a result waiting, the whole pipeline holds and
// s_tready is low.
`default_nettype none

module pid_position_motor_drive_unit
  import pidm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [2*POS_W-1:0]    s_tdata,   // [31:0] target_pos, [63:32] measured_pos
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [LIMIT_W-1:0]         m_tdata,   // [15:0] duty
  output logic [1:0]                 m_tuser,   // [0] forward, [1] clamped
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NSTAGE = 7;

  logic [GAIN_W-1:0]  prop_gain;
  logic [GAIN_W-1:0]  integ_gain;
  logic [GAIN_W-1:0]  deriv_gain;
  logic [LIMIT_W-1:0] drive_limit;

  logic              en;
  logic [NSTAGE-1:0] vld;

  logic [DIFF_W-1:0]       pos_diff;
  logic [POS_W-1:0]        err1;
  logic [POS_W-1:0]        err2;
  logic [DIFF_W-1:0]       diff2;
  logic [POS_W-1:0]        last_err;
  logic [SUM_W-1:0]        err_sum;
  logic [SUM_W:0]          sum_wide;
  logic [SUM_W-1:0]        err_sum_next;
  logic [PROD_W-1:0]       prop_p;
  logic [PROD_W-1:0]       integ_p;
  logic [PROD_W-1:0]       deriv_p;
  logic [PROD_W-1:0]       pd_sum;
  logic [PROD_W-1:0]       integ_d;
  logic [PROD_W-1:0]       acc;
  logic [PROD_W-1:0]       lim_ext;
  logic [PROD_W-1:0]       acc_plus_lim;
  logic [PROD_W-1:0]       acc_neg;
  logic                    over;
  logic [LIMIT_W-1:0]      duty_next;

  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= PROP_GAIN_RST;
      integ_gain  <= INTEG_GAIN_RST;
      deriv_gain  <= DERIV_GAIN_RST;
      drive_limit <= DRIVE_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PROP_GAIN:   prop_gain   <= cfg_data;
        CFG_INTEG_GAIN:  integ_gain  <= cfg_data;
        CFG_DERIV_GAIN:  deriv_gain  <= cfg_data;
        CFG_DRIVE_LIMIT: drive_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline valids; every stage moves together.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vld      <= {vld[NSTAGE-2:0], s_tvalid};
      m_tvalid <= vld[NSTAGE-1];
    end
  end

  // Stage 1: error, saturated to the position width.
  assign pos_diff = {s_tdata[POS_W-1], s_tdata[POS_W-1:0]}
                  - {s_tdata[2*POS_W-1], s_tdata[2*POS_W-1:POS_W]};

  always_ff @(posedge clk) begin
    if (en) begin
      if (pos_diff[DIFF_W-1] != pos_diff[POS_W-1]) begin
        err1 <= pos_diff[DIFF_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end else begin
        err1 <= pos_diff[POS_W-1:0];
      end
    end
  end

  // Stage 2: integral and previous error. The state moves only when an item enters.
  assign sum_wide = {err_sum[SUM_W-1], err_sum}
                  + {{(SUM_W+1-POS_W){err1[POS_W-1]}}, err1};

  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      err_sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      err_sum_next = sum_wide[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err_sum  <= '0;
      last_err <= '0;
    end else if (en && vld[0]) begin
      err_sum  <= err_sum_next;
      last_err <= err1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err2  <= err1;
      diff2 <= {err1[POS_W-1], err1} - {last_err[POS_W-1], last_err};
    end
  end

  // Stages 3 to 5: gain products. err_sum already holds the integral of the item in stage 2.
  pidm_gain_mul u_prop_mul (
    .clk  (clk),
    .en   (en),
    .gain (prop_gain),
    .val  ($signed({{(SUM_W-POS_W){err2[POS_W-1]}}, err2})),
    .prod (prop_p)
  );

  pidm_gain_mul u_integ_mul (
    .clk  (clk),
    .en   (en),
    .gain (integ_gain),
    .val  ($signed(err_sum)),
    .prod (integ_p)
  );

  pidm_gain_mul u_deriv_mul (
    .clk  (clk),
    .en   (en),
    .gain (deriv_gain),
    .val  ($signed({{(SUM_W-DIFF_W){diff2[DIFF_W-1]}}, diff2})),
    .prod (deriv_p)
  );

  // Stages 6 and 7: sum of the three products, exact at this width.
  always_ff @(posedge clk) begin
    if (en) begin
      pd_sum  <= prop_p + deriv_p;
      integ_d <= integ_p;
      acc     <= pd_sum + integ_d;
    end
  end

  // Clamp against the limit in fixed point; a negative sum is over the limit
  // exactly when adding the limit still leaves it negative.
  assign lim_ext      = {{(PROD_W-LIMIT_W-FRAC_W){1'b0}}, drive_limit, {FRAC_W{1'b0}}};
  assign acc_plus_lim = acc + lim_ext;
  assign acc_neg      = '0 - acc;

  always_comb begin
    if (acc[PROD_W-1]) begin
      over = acc_plus_lim[PROD_W-1];
    end else begin
      over = acc > lim_ext;
    end
    if (over) begin
      duty_next = drive_limit;
    end else if (acc[PROD_W-1]) begin
      duty_next = acc_neg[FRAC_W+LIMIT_W-1:FRAC_W];
    end else begin
      duty_next = acc[FRAC_W+LIMIT_W-1:FRAC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata    <= duty_next;
      m_tuser[0] <= !acc[PROD_W-1];
      m_tuser[1] <= over;
    end
  end

  // Assertions.
  a_sum_hold: assert property (@(posedge clk) disable iff (rst)
    !(en && vld[0]) |=> $stable(err_sum) && $stable(last_err))
    else $error("integral or previous error changed without an entering item");

  a_last_err: assert property (@(posedge clk) disable iff (rst)
    (en && vld[0]) |=> last_err == $past(err1))
    else $error("previous error does not follow the entering item");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(vld[NSTAGE-1]))
    else $error("result appeared without an item in the last stage");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> (vld == '0) && !m_tvalid && (err_sum == '0) && (last_err == '0))
    else $error("pipeline or state not cleared by reset");

endmodule

`default_nettype wire

/* hdl/pidm_gain_mul.sv */
// Three-stage pipelined multiply of an unsigned gain by a signed 48-bit value.
// Depends on pidm_pkg for the widths and the split of the operands.
`default_nettype none

module pidm_gain_mul
  import pidm_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [GAIN_W-1:0]        gain,
  input  wire logic signed [SUM_W-1:0]  val,
  output logic      [PROD_W-1:0]        prod   // two's complement
);

  localparam int P00_W = GAIN_LO_W + VAL_LO_W;
  localparam int P10_W = GAIN_HI_W + VAL_LO_W;
  localparam int P01_W = GAIN_LO_W + VAL_HI_W + 1;
  localparam int P11_W = GAIN_HI_W + VAL_HI_W + 1;

  logic        [P00_W-1:0] p00;
  logic        [P10_W-1:0] p10;
  logic signed [P01_W-1:0] p01;
  logic signed [P11_W-1:0] p11;
  logic        [LO_W-1:0]  lo;
  logic        [HI_W-1:0]  hi;

  // The low half of the value is unsigned; the high half carries the sign.
  always_ff @(posedge clk) begin
    if (en) begin
      p00 <= gain[GAIN_LO_W-1:0] * val[VAL_LO_W-1:0];
      p10 <= gain[GAIN_W-1:GAIN_LO_W] * val[VAL_LO_W-1:0];
      p01 <= $signed({1'b0, gain[GAIN_LO_W-1:0]}) * $signed(val[SUM_W-1:VAL_LO_W]);
      p11 <= $signed({1'b0, gain[GAIN_W-1:GAIN_LO_W]}) * $signed(val[SUM_W-1:VAL_LO_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo <= {{(LO_W - P00_W){1'b0}}, p00} + {1'b0, p10, {GAIN_LO_W{1'b0}}};
      hi <= {{(HI_W - P01_W){p01[P01_W-1]}}, p01} + {p11[P11_W-1], p11, {GAIN_LO_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= {{(PROD_W - LO_W){1'b0}}, lo} + {hi, {VAL_LO_W{1'b0}}};
    end
  end

endmodule

`default_nettype wire

/* tb/pidm_drive_tb_pkg.sv */
// Scoreboard for the PID position motor drive testbench: a cycle-free model of the
// controller and the queue of drive results still owed by the block.
// Depends on pidm_pkg for widths, reset values and register indexes.
`timescale 1ns / 1ps

package pidm_drive_tb_pkg;
  import pidm_pkg::*;

  typedef struct packed {
    logic [LIMIT_W-1:0] duty;
    logic               forward;
    logic               clamped;
  } drive_result_t;

  class drive_scoreboard;
    logic [GAIN_W-1:0]         prop_gain;
    logic [GAIN_W-1:0]         integ_gain;
    logic [GAIN_W-1:0]         deriv_gain;
    logic [LIMIT_W-1:0]        drive_limit;
    logic signed [SUM_W-1:0]   integral;
    logic signed [POS_W-1:0]   prev_err;
    drive_result_t             owed_q[$];
    int unsigned               requests;
    int unsigned               results;
    int unsigned               mismatches;
    int unsigned               clamp_count;
    int unsigned               sat_ticks;
    int unsigned               settings;

    function new();
      prop_gain   = PROP_GAIN_RST;
      integ_gain  = INTEG_GAIN_RST;
      deriv_gain  = DERIV_GAIN_RST;
      drive_limit = DRIVE_LIMIT_RST;
      integral    = '0;
      prev_err    = '0;
      requests    = 0;
      results     = 0;
      mismatches  = 0;
      clamp_count = 0;
      sat_ticks   = 0;
      settings    = 1;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_PROP_GAIN:   prop_gain   = data[GAIN_W-1:0];
        CFG_INTEG_GAIN:  integ_gain  = data[GAIN_W-1:0];
        CFG_DERIV_GAIN:  deriv_gain  = data[GAIN_W-1:0];
        CFG_DRIVE_LIMIT: drive_limit = data[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function logic signed [127:0] gain_product(logic [GAIN_W-1:0] gain,
                                               logic signed [SUM_W-1:0] value);
      logic signed [127:0] g;
      logic signed [127:0] v;
      g = {{(128-GAIN_W){1'b0}}, gain};
      v = value;
      return g * v;
    endfunction

    function void note_request(logic [POS_W-1:0] target, logic [POS_W-1:0] measured);
      logic [POS_W:0]            raw;
      logic signed [POS_W-1:0]   err;
      logic signed [POS_W:0]     delta;
      logic [SUM_W:0]            sum_wide;
      logic signed [127:0]       acc;
      logic [127:0]              mag;
      logic [127:0]              ceiling;
      drive_result_t             res;
      raw = {target[POS_W-1], target} - {measured[POS_W-1], measured};
      // The top two bits disagree only when the difference left the position range.
      if (raw[POS_W] != raw[POS_W-1])
        err = raw[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      else
        err = raw[POS_W-1:0];
      delta = {err[POS_W-1], err} - {prev_err[POS_W-1], prev_err};
      prev_err = err;
      sum_wide = {integral[SUM_W-1], integral} + {{(SUM_W-POS_W+1){err[POS_W-1]}}, err};
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
        integral = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        sat_ticks++;
      end else begin
        integral = sum_wide[SUM_W-1:0];
      end
      acc = gain_product(prop_gain, err) + gain_product(integ_gain, integral)
          + gain_product(deriv_gain, delta);
      mag = acc[127] ? -acc : acc;
      ceiling = {{(128-LIMIT_W){1'b0}}, drive_limit} << FRAC_W;
      res.forward = !acc[127];
      res.clamped = mag > ceiling;
      res.duty    = res.clamped ? drive_limit : mag[FRAC_W +: LIMIT_W];
      if (res.clamped) clamp_count++;
      owed_q.push_back(res);
      requests++;
    endfunction

    function void check_result(logic [LIMIT_W-1:0] duty, logic [1:0] flags);
      drive_result_t want;
      results++;
      if (owed_q.size() == 0) begin
        $error("drive result with no request outstanding: duty %0d forward %0d clamped %0d",
               duty, flags[0], flags[1]);
        mismatches++;
        return;
      end
      want = owed_q.pop_front();
      if (duty !== want.duty) begin
        $error("duty: expected %0d, got %0d", want.duty, duty);
        mismatches++;
      end
      if (flags[0] !== want.forward) begin
        $error("forward: expected %0d, got %0d", want.forward, flags[0]);
        mismatches++;
      end
      if (flags[1] !== want.clamped) begin
        $error("clamped: expected %0d, got %0d", want.clamped, flags[1]);
        mismatches++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

endpackage

/* tb/tb_pid_position_motor_drive_unit.sv */
// Top-level testbench for pid_position_motor_drive_unit: directed corner requests
// and random requests under several gain settings with varied back-pressure.
// Depends on pidm_pkg and on the scoreboard in pidm_drive_tb_pkg.
`timescale 1ns / 1ps

module tb_pid_position_motor_drive_unit;
  import pidm_pkg::*;
  import pidm_drive_tb_pkg::*;

  localparam logic [POS_W-1:0]  POS_MAX  = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0]  POS_MIN  = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
  localparam logic [GAIN_W-1:0] UNIT_GAIN = GAIN_W'(1) << FRAC_W;
  localparam int RESULT_LATENCY = 7;
  localparam int LONG_HOLD_CYCLES = 300;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [2*POS_W-1:0]    s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [LIMIT_W-1:0]    m_tdata;
  logic [1:0]            m_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bit long_hold;
  bit ready_free;
  drive_scoreboard sb;

  pid_position_motor_drive_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("pid_position_motor_drive_unit regression: fail");
    $finish;
  end

  // Output side: random back-pressure, with an optional long hold-off.
  initial begin
    int stall_left;
    int r;
    stall_left = 0;
    m_tready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
      end else if (ready_free) begin
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        r = $urandom_range(0, 99);
        if (r < 65)      stall_left = 0;
        else if (r < 92) stall_left = $urandom_range(1, 3);
        else if (r < 98) stall_left = $urandom_range(4, 12);
        else             stall_left = $urandom_range(20, 50);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata, m_tuser);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    logic [31:0] a;
    logic [31:0] b;
    a = $urandom;
    b = $urandom;
    case ($urandom_range(0, 9))
      0:          return '0;
      1:          return GAIN_MAX;
      2, 3, 4, 5: return GAIN_W'($urandom_range(0, 1 << 26));
      6, 7:       return GAIN_W'($urandom_range(0, 1 << 16));
      default:    return {a[7:0], b};
    endcase
  endfunction

  // Upper data bits are sometimes junk: the limit register keeps only its low bits.
  function automatic logic [CFG_DATA_W-1:0] pick_limit();
    logic [31:0] junk;
    logic [LIMIT_W-1:0] lim;
    junk = $urandom;
    case ($urandom_range(0, 4))
      0:       lim = '0;
      1:       lim = '1;
      2:       lim = LIMIT_W'($urandom_range(0, 2000));
      default: lim = LIMIT_W'($urandom);
    endcase
    if ($urandom_range(0, 3) == 0)
      return {junk[CFG_DATA_W-LIMIT_W-1:0], lim};
    return CFG_DATA_W'(lim);
  endfunction

  function automatic logic [POS_W-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0:       return POS_MAX;
      1:       return POS_MIN;
      2:       return '0;
      3:       return '1;
      default: return POS_W'(1);
    endcase
  endfunction

  task automatic send_request(input logic [POS_W-1:0] target,
                              input logic [POS_W-1:0] measured, input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {measured, target};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(target, measured);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic configure(input logic [GAIN_W-1:0] prop, input logic [GAIN_W-1:0] integ,
                           input logic [GAIN_W-1:0] deriv, input logic [CFG_DATA_W-1:0] lim);
    write_reg(CFG_PROP_GAIN, prop);
    write_reg(CFG_INTEG_GAIN, integ);
    write_reg(CFG_DERIV_GAIN, deriv);
    write_reg(CFG_DRIVE_LIMIT, lim);
    cfg_valid <= 1'b0;
    sb.settings++;
  endtask

  // Stop offering requests and let every owed result come back.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (RESULT_LATENCY + 2) @(negedge clk);
  endtask

  task automatic random_phase(input int count, input bit burst, input bit squeeze);
    logic [POS_W-1:0]        target;
    logic [POS_W-1:0]        measured;
    logic signed [POS_W-1:0] err;
    logic signed [POS_W-1:0] offset;
    logic signed [SUM_W-1:0] held;
    int cls;
    int gap;
    for (int n = 0; n < count; n++) begin
      cls = $urandom_range(0, 99);
      target = $urandom;
      if (cls < 45) begin
        measured = target - ($urandom_range(0, 200) - 100);
      end else if (cls < 65) begin
        measured = target - ($urandom_range(0, 131072) - 65536);
      end else if (cls < 75) begin
        measured = $urandom;
      end else if (cls < 83) begin
        target = pick_extreme();
        measured = pick_extreme();
      end else begin
        // Pull the integral back toward zero so later drives are not all clamped.
        held = sb.integral;
        if (held >= $signed(SUM_W'(POS_MAX)))
          err = -$signed(POS_MAX);
        else if (held <= -$signed(SUM_W'(POS_MAX)))
          err = POS_MAX;
        else
          err = -held[POS_W-1:0];
        offset = '0;
        if (err > -(1 <<< 30) && err < (1 <<< 30))
          offset = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
        target = err + offset;
        measured = offset;
      end
      if (squeeze && n == count / 3)
        long_hold = 1'b1;
      if (burst || (squeeze && n >= count / 3 && n < count / 3 + 60) || (n % 100) < 12)
        gap = 0;
      else
        gap = pick_gap();
      send_request(target, measured, gap);
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_PROP_GAIN;
    cfg_data = '0;
    long_hold = 1'b0;
    ready_free = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset gains: zero, small, saturating errors both ways, alternating bit patterns.
    send_request('0, '0, 0);
    send_request(POS_W'(100), '0, pick_gap());
    send_request('0, POS_W'(100), pick_gap());
    send_request(POS_MAX, POS_MIN, 0);
    send_request(POS_MIN, POS_MAX, 0);
    send_request(POS_MIN, POS_MIN, pick_gap());
    send_request(POS_MAX, POS_MAX, 0);
    send_request('1, '0, pick_gap());
    send_request(32'h5555_5555, 32'hAAAA_AAAA, 0);
    send_request(32'hAAAA_AAAA, 32'h5555_5555, pick_gap());
    wait_idle();

    // A drive of one fraction step: a tiny negative drive truncates to zero in reverse.
    configure(GAIN_W'(1), '0, '0, {24'hA5A5A5, 16'd999});
    send_request('0, POS_W'(1), 0);
    send_request(POS_W'(1), '0, 0);
    send_request('0, '0, 0);
    wait_idle();

    // Unit gain: the drive equal to the limit is not clamped, one tick more is.
    configure(UNIT_GAIN, '0, '0, CFG_DATA_W'(999));
    send_request(POS_W'(999), '0, 0);
    send_request(POS_W'(1000), '0, pick_gap());
    send_request('0, POS_W'(999), 0);
    send_request('0, POS_W'(1000), 0);
    wait_idle();

    // Zero limit: duty stays zero and only a nonzero drive is flagged.
    configure(UNIT_GAIN, '0, '0, '0);
    send_request('0, '0, 0);
    send_request(POS_W'(1), '0, 0);
    send_request('0, POS_W'(1), 0);
    wait_idle();

    configure(GAIN_MAX, GAIN_MAX, GAIN_MAX, CFG_DATA_W'(16'hFFFF));
    send_request(POS_MAX, POS_MIN, 0);
    send_request(POS_MIN, POS_MAX, 0);
    send_request('0, '0, 0);
    wait_idle();

    for (int k = 0; k < 7; k++) begin
      if (k == 0)
        configure('0, '0, '0, '0);
      else if (k == 1)
        configure(GAIN_MAX, GAIN_MAX, GAIN_MAX, CFG_DATA_W'(16'hFFFF));
      else
        configure(pick_gain(), pick_gain(), pick_gain(), pick_limit());
      ready_free = (k == 2);
      random_phase((k < 2) ? 100 : 260, k == 2, k == 4);
      wait_idle();
    end
    ready_free = 1'b0;

    configure(pick_gain(), GAIN_W'(1), pick_gain(), pick_limit());
    random_phase(40, 1'b0, 1'b0);
    wait_idle();

    $display("Checked %0d drive results for %0d requests under %0d register settings.",
             sb.results, sb.requests, sb.settings);
    $display("Drive clamped on %0d ticks; integral held at a rail on %0d ticks.",
             sb.clamp_count, sb.sat_ticks);
    if (sb.mismatches == 0)
      $display("pid_position_motor_drive_unit regression: pass");
    else
      $display("pid_position_motor_drive_unit regression: fail");
    $finish;
  end

endmodule
